// ----- hdl/pms_pkg.sv -----
// Shared types, constants and command/status bundles for the pointer motion session speed block.
package pms_pkg;

  localparam int TIME_W  = 48;
  localparam int GAP_W   = 24;
  localparam int CNT_W   = 16;
  localparam int DELTA_W = 16;
  localparam int ROOT_W  = 24;
  localparam int US_W    = 20;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [GAP_W-1:0]  GAP_RESET    = GAP_W'(50000);
  localparam logic [CNT_W-1:0]  WARMUP_RESET = CNT_W'(100);
  localparam logic [US_W-1:0]   US_PER_S     = US_W'(1000000);
  localparam logic [TIME_W-1:0] TIME_MAX     = '1;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_GAP    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_WARMUP = CFG_IDX_W'(1);

  // Iteration counts of the shared-nothing sequential units
  localparam int ROOT_STEPS = ROOT_W;
  localparam int DIV_STEPS  = TIME_W;
  localparam int ROOT_CNT_W = $clog2(ROOT_STEPS);
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  typedef struct packed {
    logic signed [DELTA_W-1:0] delta_x;
    logic signed [DELTA_W-1:0] delta_y;
    logic [TIME_W-1:0]         event_time_us;
  } pms_in_t;

  typedef struct packed {
    logic [TIME_W-1:0] start_time_us;
    logic [TIME_W-1:0] end_time_us;
    logic [TIME_W-1:0] duration_us;
    logic [TIME_W-1:0] average_speed;
  } pms_out_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic check;
    logic mul;
    logic div_load;
    logic emit;
    logic update;
  } pms_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_nonzero;
    logic report;
    logic div_done;
    logic out_free;
    logic root_done;
  } pms_stat_t;

endpackage

// ----- hdl/pms_ctrl.sv -----
// Sequencing state machine for the pointer motion session speed block.
module pms_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  pms_pkg::pms_stat_t stat,
  output pms_pkg::pms_cmd_t  cmd
);
  import pms_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_DIVLD = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_stall = (state != S_IDLE);

  // Decode commands and next state
  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        cmd.capture = in_valid;
        if (in_valid && stat.in_nonzero) state_next = S_CHECK;
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        state_next = stat.report ? S_MUL : S_FIN;
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        state_next = S_DIVLD;
      end
      S_DIVLD: begin
        cmd.div_load = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (stat.div_done) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (stat.root_done) begin
          cmd.update = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

endmodule

// ----- hdl/pms_dp.sv -----
// Datapath: session state, integer square root, speed divider and output register.
module pms_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  pms_pkg::pms_in_t                in_item,
  input  logic                            cfg_valid,
  input  logic [pms_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pms_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output pms_pkg::pms_out_t               out_item,
  input  pms_pkg::pms_cmd_t               cmd,
  output pms_pkg::pms_stat_t              stat
);
  import pms_pkg::*;

  // Configuration
  logic [GAP_W-1:0] gap_threshold_us;
  logic [CNT_W-1:0] warmup_sessions;

  // Session state
  logic [CNT_W-1:0]  session_count;
  logic [CNT_W-1:0]  events_in_session;
  logic [TIME_W-1:0] session_start_time;
  logic [TIME_W-1:0] last_event_time;
  logic [TIME_W-1:0] path_length_q8;

  // Captured event
  logic [DELTA_W-1:0] mag_x;
  logic [DELTA_W-1:0] mag_y;
  logic [TIME_W-1:0]  ev_time;
  logic               close_r;
  logic [TIME_W-1:0]  dur;

  // Square root unit
  logic [TIME_W-1:0]     rad;
  logic [ROOT_W-1:0]     root;
  logic [ROOT_W+2:0]     srem;
  logic [ROOT_CNT_W-1:0] root_cnt;
  logic                  root_busy;

  // Multiplier and divider
  logic [GAP_W+US_W-1:0] pp_lo;
  logic [GAP_W+US_W-1:0] pp_hi;
  logic [TIME_W-1:0]     drem;
  logic [TIME_W-1:0]     dq;
  logic [DIV_CNT_W-1:0]  div_cnt;
  logic                  div_busy;
  logic                  div_sat;

  // Combinational helpers
  logic [TIME_W-1:0]         gap;
  logic                      close_now;
  logic                      report_now;
  logic [2*DELTA_W-1:0]      sumsq;
  logic [ROOT_W+2:0]         srem_sh;
  logic [ROOT_W+2:0]         strial;
  logic [TIME_W+US_W-1:0]    prod;
  logic [US_W-1:0]           prod_top;
  logic [TIME_W:0]           dtrial;
  logic [TIME_W:0]           path_sum;
  logic [CNT_W-1:0]          ev_base;
  logic [TIME_W-1:0]         path_base;

  // Session close decision for the captured event
  assign gap        = ev_time - last_event_time;
  assign close_now  = (events_in_session != '0) && (gap > TIME_W'(gap_threshold_us));
  assign report_now = close_now && (session_count >= warmup_sessions)
                      && (events_in_session >= CNT_W'(2));

  assign sumsq = (2*DELTA_W)'(mag_x * mag_x) + (2*DELTA_W)'(mag_y * mag_y);

  assign srem_sh = {srem[ROOT_W:0], rad[TIME_W-1 -: 2]};
  assign strial  = {1'b0, root, 2'b01};

  assign prod     = {pp_hi, {GAP_W{1'b0}}} + (TIME_W+US_W)'(pp_lo);
  assign prod_top = prod[TIME_W+US_W-1:TIME_W];
  assign dtrial   = {drem, dq[TIME_W-1]};

  assign ev_base   = close_r ? '0 : events_in_session;
  assign path_base = close_r ? '0 : path_length_q8;
  assign path_sum  = {1'b0, path_base} + (TIME_W+1)'(root);

  assign stat.in_nonzero = (in_item.delta_x != '0) || (in_item.delta_y != '0);
  assign stat.report     = report_now;
  assign stat.div_done   = !div_busy;
  assign stat.out_free   = !out_valid || !out_stall;
  assign stat.root_done  = !root_busy;

  // Take configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      gap_threshold_us <= GAP_RESET;
      warmup_sessions  <= WARMUP_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_GAP:    gap_threshold_us <= cfg_data[GAP_W-1:0];
        CFG_WARMUP: warmup_sessions  <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture event magnitudes and time on transfer
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mag_x   <= in_item.delta_x[DELTA_W-1] ? DELTA_W'(-in_item.delta_x) : in_item.delta_x;
      mag_y   <= in_item.delta_y[DELTA_W-1] ? DELTA_W'(-in_item.delta_y) : in_item.delta_y;
      ev_time <= in_item.event_time_us;
    end
    if (cmd.check) begin
      close_r <= close_now;
      dur     <= last_event_time - session_start_time;
    end
  end

  // Square root: one result bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      root_busy <= 1'b0;
    end else if (cmd.check) begin
      rad       <= {sumsq, {(TIME_W-2*DELTA_W){1'b0}}};
      root      <= '0;
      srem      <= '0;
      root_cnt  <= '0;
      root_busy <= 1'b1;
    end else if (root_busy) begin
      rad <= {rad[TIME_W-3:0], 2'b00};
      if (srem_sh >= strial) begin
        srem <= srem_sh - strial;
        root <= {root[ROOT_W-2:0], 1'b1};
      end else begin
        srem <= srem_sh;
        root <= {root[ROOT_W-2:0], 1'b0};
      end
      root_cnt <= root_cnt + 1'b1;
      if (root_cnt == ROOT_CNT_W'(ROOT_STEPS-1)) root_busy <= 1'b0;
    end
  end

  // Path times one million, as two registered partial products
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      pp_lo <= (GAP_W+US_W)'(path_length_q8[GAP_W-1:0]) * (GAP_W+US_W)'(US_PER_S);
      pp_hi <= (GAP_W+US_W)'(path_length_q8[TIME_W-1:GAP_W]) * (GAP_W+US_W)'(US_PER_S);
    end
  end

  // Divider: quotient bits above 48 only decide saturation, then 48 restoring steps
  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
    end else if (cmd.div_load) begin
      div_sat  <= (dur == '0) || (TIME_W'(prod_top) >= dur);
      drem     <= TIME_W'(prod_top);
      dq       <= prod[TIME_W-1:0];
      div_cnt  <= '0;
      div_busy <= 1'b1;
    end else if (div_busy) begin
      if (dtrial >= {1'b0, dur}) begin
        drem <= TIME_W'(dtrial - {1'b0, dur});
        dq   <= {dq[TIME_W-2:0], 1'b1};
      end else begin
        drem <= dtrial[TIME_W-1:0];
        dq   <= {dq[TIME_W-2:0], 1'b0};
      end
      div_cnt <= div_cnt + 1'b1;
      if (div_cnt == DIV_CNT_W'(DIV_STEPS-1)) div_busy <= 1'b0;
    end
  end

  // Output register: load a result, drop it once transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_item.start_time_us <= session_start_time;
      out_item.end_time_us   <= last_event_time;
      out_item.duration_us   <= dur;
      out_item.average_speed <= div_sat ? TIME_MAX : dq;
    end
  end

  // Advance session state at the end of each counted event
  always_ff @(posedge clk) begin
    if (rst) begin
      session_count      <= '0;
      events_in_session  <= '0;
      session_start_time <= '0;
      last_event_time    <= '0;
      path_length_q8     <= '0;
    end else if (cmd.update) begin
      if (close_r && (session_count != '1)) session_count <= session_count + 1'b1;
      if (ev_base == '0) begin
        session_start_time <= ev_time;
        path_length_q8     <= path_base;
      end else begin
        path_length_q8 <= path_sum[TIME_W] ? TIME_MAX : path_sum[TIME_W-1:0];
      end
      last_event_time   <= ev_time;
      events_in_session <= (ev_base == '1) ? ev_base : ev_base + 1'b1;
    end
  end

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || !out_stall))
    else $error("result loaded over an untaken result");

  a_update_root: assert property (@(posedge clk) disable iff (rst)
    cmd.update |-> !root_busy)
    else $error("session updated before square root finished");

  a_update_count: assert property (@(posedge clk) disable iff (rst)
    cmd.update |=> (events_in_session != '0))
    else $error("event count zero after a counted event");

  a_div_start: assert property (@(posedge clk) disable iff (rst)
    cmd.div_load |=> div_busy)
    else $error("divider did not start");

endmodule

// ----- hdl/pointer_motion_session_speed_top.sv -----
// An event that closes no reported session is done after the check, the square root
// (24 steps, run from the check on) and the update; a reporting event also passes the multiply,
// the divider load, the 48-step restoring divider and the result load before its update.
// A new event is taken only once the block is back in idle, and a waiting result that is stalled
// holds it longer; zero-motion events are taken while idle and leave the session state unchanged.
// Reset (rst, synchronous): session state clears to zero, configuration registers return to their defaults.
module pointer_motion_session_speed_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  pms_pkg::pms_in_t                in_item,
  output logic                            out_valid,
  input  logic                            out_stall,
  output pms_pkg::pms_out_t               out_item,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pms_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pms_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import pms_pkg::*;

  pms_cmd_t  cmd;
  pms_stat_t stat;

  assign cfg_ready = 1'b1;

  pms_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  pms_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
